@@ rtl/normalized_3x3_convolution_core_macros.svh @@
`ifndef NORMALIZED_3X3_CONVOLUTION_CORE_MACROS_SVH
`define NORMALIZED_3X3_CONVOLUTION_CORE_MACROS_SVH
// assertion helpers
`define N3C_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("n3c check failed");
`define N3C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("n3c check failed");
`endif

@@ rtl/n3c_pkg.sv @@
`timescale 1ns / 1ps
package n3c_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COEF_BITS = 16;
    localparam int MAX_HEIGHT = 4096;
    localparam int LS_AW = $clog2(MAX_WIDTH);
    localparam int NUM_BITS = 8 + COEF_BITS + 4 + 8;
    localparam int DEN_BITS = COEF_BITS + 4;
    localparam int QUO_BITS = 17;

    localparam logic [2:0] REG_K_TOP = 3'd0;
    localparam logic [2:0] REG_K_MID = 3'd1;
    localparam logic [2:0] REG_K_BOT = 3'd2;
    localparam logic [2:0] REG_WIDTH = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic [8:0][7:0] win;
        logic [11:0] row;
        logic [9:0] col;
        logic last;
    } job_t;

    typedef struct packed {
        logic [16:0] filtered_value;
        logic [11:0] out_row;
        logic [9:0] out_col;
        logic last;
    } result_t;
endpackage

@@ rtl/n3c_if.sv @@
`timescale 1ns / 1ps
interface n3c_pix_if (input logic clk);
    logic valid;
    logic ready;
    logic [7:0] pixel;
    logic frame_start;
    modport source (output valid, pixel, frame_start, input ready);
    modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface n3c_res_if (input logic clk);
    logic valid;
    logic ready;
    logic signed [16:0] filtered_value;
    logic [11:0] out_row;
    logic [9:0] out_col;
    logic last;
    modport source (output valid, filtered_value, out_row, out_col, last, input ready);
    modport sink (input valid, filtered_value, out_row, out_col, last, output ready);
endinterface

interface n3c_cfg_if (input logic clk);
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/n3c_ram.sv @@
`timescale 1ns / 1ps
module n3c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/n3c_front.sv @@
`timescale 1ns / 1ps
module n3c_front (
    input  logic          clk,
    input  logic          rst_n,
    n3c_pix_if.sink       pix,
    input  logic [10:0]   image_width,
    input  logic [12:0]   image_height,
    output logic          job_valid,
    output n3c_pkg::job_t job,
    input  logic          job_ready
);
    import n3c_pkg::*;

    // sequential: accept, read line store, then update window
    typedef enum logic [1:0] {S_IDLE, S_READ, S_PUSH} state_t;
    state_t state_reg;

    logic [7:0]  px_reg;
    logic [9:0]  col_reg;
    logic [11:0] row_reg;
    logic [9:0]  c_cur_reg;
    logic [8:0][7:0] win_reg;
    logic        job_valid_reg;
    job_t        job_reg;
    logic        emit_reg;
    logic        clr_reg;
    logic [LS_AW:0] clr_cnt_reg;

    logic [11:0] w_eff;
    logic [12:0] h_eff;
    logic [7:0]  top_rd, mid_rd;
    logic        ls_we;
    logic [LS_AW-1:0] ls_addr;

    always_comb
    begin
        w_eff = (image_width < 11'd3) ? 12'd3 :
                (image_width > 11'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : {1'b0, image_width};
        h_eff = (image_height < 13'd3) ? 13'd3 :
                (image_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height;
    end

    assign ls_we = clr_reg || (state_reg == S_PUSH);
    assign ls_addr = clr_reg ? clr_cnt_reg[LS_AW-1:0] : c_cur_reg[LS_AW-1:0];

    n3c_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top (
        .clk(clk), .we(ls_we), .waddr(ls_addr), .wdata(clr_reg ? 8'd0 : mid_rd),
        .re(state_reg == S_READ), .raddr(ls_addr), .rdata(top_rd)
    );
    n3c_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid (
        .clk(clk), .we(ls_we), .waddr(ls_addr), .wdata(clr_reg ? 8'd0 : px_reg),
        .re(state_reg == S_READ), .raddr(ls_addr), .rdata(mid_rd)
    );

    logic accept;
    assign pix.ready = !clr_reg && (state_reg == S_IDLE) && (!job_valid_reg || job_ready);
    assign accept = pix.valid && pix.ready;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    logic [9:0]  c_use;
    logic [11:0] r_use;
    logic [10:0] c_inc;
    logic [12:0] r_inc;
    logic emit;

    always_comb
    begin
        c_use = pix.frame_start ? 10'd0 : col_reg;
        r_use = pix.frame_start ? 12'd0 : row_reg;
        emit = (r_use >= 12'd2) && (c_use >= 10'd2) &&
               ({1'b0, r_use} < h_eff) && ({2'b0, c_use} < w_eff);
        c_inc = {1'b0, c_use} + 11'd1;
        r_inc = {1'b0, r_use} + 13'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
            job_valid_reg <= 1'b0;
            emit_reg <= 1'b0;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (job_valid_reg && job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (LS_AW+1)'(MAX_WIDTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            px_reg <= pix.pixel;
                            c_cur_reg <= c_use;
                            if ({1'b0, c_inc} >= w_eff)
                            begin
                                col_reg <= '0;
                                row_reg <= (r_inc >= h_eff) ? 12'd0 : r_inc[11:0];
                            end
                            else
                            begin
                                col_reg <= c_inc[9:0];
                                row_reg <= r_use;
                            end
                            job_reg.row <= r_use - 12'd1;
                            job_reg.col <= c_use - 10'd1;
                            job_reg.last <= ({1'b0, r_use} == h_eff - 13'd1) &&
                                            ({2'b0, c_use} == w_eff - 12'd1);
                            emit_reg <= emit;
                            state_reg <= S_READ;
                        end
                    end
                    S_READ:
                    begin
                        state_reg <= S_PUSH;
                    end
                    S_PUSH:
                    begin
                        win_reg[0] <= win_reg[1];
                        win_reg[1] <= win_reg[2];
                        win_reg[2] <= top_rd;
                        win_reg[3] <= win_reg[4];
                        win_reg[4] <= win_reg[5];
                        win_reg[5] <= mid_rd;
                        win_reg[6] <= win_reg[7];
                        win_reg[7] <= win_reg[8];
                        win_reg[8] <= px_reg;
                        job_reg.win <= {px_reg, win_reg[8:7], mid_rd, win_reg[5:4],
                                        top_rd, win_reg[2:1]};
                        job_valid_reg <= emit_reg;
                        state_reg <= S_IDLE;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end
endmodule

@@ rtl/n3c_queue.sv @@
`timescale 1ns / 1ps
module n3c_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  n3c_pkg::job_t in_job,
    output logic          in_ready,
    output logic          out_valid,
    output n3c_pkg::job_t out_job,
    input  logic          out_ready
);
    import n3c_pkg::*;
    job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic wr_ptr_reg, rd_ptr_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job = q_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_job;
        end
    end
endmodule

@@ rtl/n3c_back.sv @@
`timescale 1ns / 1ps
module n3c_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  n3c_pkg::job_t job,
    output logic          job_ready,
    input  logic [2:0][47:0] kernel,
    n3c_res_if.source     res
);
    import n3c_pkg::*;

    // MAC over 9 taps, then restoring divide 1 bit per cycle unless the coefficient magnitude sum is zero
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_SETUP, S_DIV, S_OUT} state_t;
    state_t state_reg;

    job_t job_reg;
    logic [3:0] tap_reg;
    logic signed [NUM_BITS-1:0] acc_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [DEN_BITS:0] rem_reg;
    logic [5:0] bit_reg;
    logic neg_reg;
    logic [3:0] k_idx;
    logic [1:0] k_row;
    logic [3:0] k_col;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [8+COEF_BITS:0] prod;
    logic [COEF_BITS-1:0] coef_abs;
    logic [DEN_BITS:0] rem_sh;
    logic [16:0] q_fix;

    always_comb
    begin
        k_idx = 4'd8 - tap_reg;
        k_row = (k_idx >= 4'd6) ? 2'd2 : (k_idx >= 4'd3) ? 2'd1 : 2'd0;
        k_col = k_idx - 4'(k_row) * 4'd3;
        coef = kernel[k_row][6'(k_col) * 6'(COEF_BITS) +: COEF_BITS];
        prod = $signed({1'b0, job_reg.win[tap_reg]}) * coef;
        coef_abs = coef[COEF_BITS-1] ? COEF_BITS'(-coef) : coef;
        rem_sh = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
        q_fix = 17'(num_reg);
    end

    assign job_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res.valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        tap_reg <= '0;
                        acc_reg <= '0;
                        den_reg <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    acc_reg <= acc_reg + NUM_BITS'(prod);
                    den_reg <= den_reg + DEN_BITS'(coef_abs);
                    tap_reg <= tap_reg + 4'd1;
                    if (tap_reg == 4'd8)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    neg_reg <= (den_reg == '0) ? 1'b0 : acc_reg[NUM_BITS-1];
                    num_reg <= (den_reg == '0) ? '0 :
                               (acc_reg[NUM_BITS-1] ? NUM_BITS'(-acc_reg) : acc_reg) << 8;
                    rem_reg <= '0;
                    bit_reg <= 6'(NUM_BITS);
                    state_reg <= (den_reg == '0) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        num_reg <= {num_reg[NUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd1)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!res.valid || res.ready)
                    begin
                        res.valid <= 1'b1;
                        res.filtered_value <= neg_reg ? -q_fix : q_fix;
                        res.out_row <= job_reg.row;
                        res.out_col <= job_reg.col;
                        res.last <= job_reg.last;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (res.valid && res.ready && !(state_reg == S_OUT))
            begin
                res.valid <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/normalized_3x3_convolution_core.sv @@
`timescale 1ns / 1ps
// channel | direction | beat
// pix     | in        | pixel, frame_start
// res     | out       | filtered_value, out_row, out_col, last
// cfg     | in        | index, data
// In the front a pixel is accepted, read against the line stores and shifted into the window.
// In the back a result passes through job load, 9 MAC steps, setup, a 1-bit-per-cycle divide
// and the output beat; with a zero coefficient sum the divide is skipped.
// After reset the line stores clear all MAX_WIDTH addresses before pix is ready.
// A two-entry queue lets the front run ahead of the divider; either side stalls on its own.
module normalized_3x3_convolution_core (
    input logic      clk,
    input logic      rst_n,
    n3c_pix_if.sink  pix,
    n3c_res_if.source res,
    n3c_cfg_if.sink  cfg
);
    import n3c_pkg::*;

    logic [2:0][47:0] kernel_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic fj_valid, fj_ready, bj_valid, bj_ready;
    job_t fj, bj;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= {48'd0, 48'd16777216, 48'd0};
            width_reg <= 11'd1024;
            height_reg <= 13'd1024;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_K_TOP: kernel_reg[0] <= cfg.data;
                REG_K_MID: kernel_reg[1] <= cfg.data;
                REG_K_BOT: kernel_reg[2] <= cfg.data;
                REG_WIDTH: width_reg <= cfg.data[10:0];
                REG_HEIGHT: height_reg <= cfg.data[12:0];
                default: ;
            endcase
        end
    end

    n3c_front u_front (
        .clk(clk), .rst_n(rst_n), .pix(pix), .image_width(width_reg),
        .image_height(height_reg), .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
    );
    n3c_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(fj_valid), .in_job(fj), .in_ready(fj_ready),
        .out_valid(bj_valid), .out_job(bj), .out_ready(bj_ready)
    );
    n3c_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job(bj), .job_ready(bj_ready),
        .kernel(kernel_reg), .res(res)
    );
endmodule

@@ rtl/n3c_checker.sv @@
`timescale 1ns / 1ps
`include "normalized_3x3_convolution_core_macros.svh"
module n3c_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic [11:0] res_row,
    input logic [9:0] res_col,
    input logic signed [16:0] res_value
);
    `N3C_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid)
    `N3C_ASSERT_IMPL(a_row, res_valid, res_row != 12'd0)
    `N3C_ASSERT_IMPL(a_col, res_valid, res_col != 10'd0)
    `N3C_ASSERT_IMPL(a_range, res_valid, (res_value <= 17'sd65280) && (res_value >= -17'sd65280))
endmodule

bind normalized_3x3_convolution_core n3c_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .res_row(res.out_row), .res_col(res.out_col), .res_value(res.filtered_value)
);
